// ----- design/prps_pkg.sv -----
// ----------------------------------------------------------------------------
// prps_pkg
// Shared types and constants for the per-source packet reassembly tracker.
// ----------------------------------------------------------------------------
package prps_pkg;

	localparam int SOURCES_DEF       = 16;
	localparam int CHUNK_PAYLOAD_DEF = 30;
	localparam int QUEUE_DEPTH_DEF   = 2;

	localparam int SIZE_W = 16;
	localparam int CNT_W  = 12;

	localparam logic [3:0] SPECIAL_NODE    = 4'hf;
	localparam logic [4:0] SPECIAL_CHANNEL = 5'd16;

	localparam logic [7:0] ACK_RESET   = 8'd1;
	localparam logic [7:0] NOACK_RESET = 8'd2;

	// configuration register indexes
	localparam logic CFG_ACK   = 1'b0;
	localparam logic CFG_NOACK = 1'b1;

	// result event codes
	localparam logic [2:0] EV_STATUS = 3'd0;
	localparam logic [2:0] EV_START  = 3'd1;
	localparam logic [2:0] EV_PLACED = 3'd2;
	localparam logic [2:0] EV_DONE   = 3'd3;
	localparam logic [2:0] EV_REPEAT = 3'd4;
	localparam logic [2:0] EV_ORPHAN = 3'd5;

	typedef enum logic [2:0] {
		K_SPECIAL = 3'd0,
		K_OOB     = 3'd1,
		K_STATUS  = 3'd2,
		K_CMD     = 3'd3,
		K_DATA    = 3'd4
	} item_kind_t;

	typedef struct packed {
		item_kind_t         kind;
		logic [3:0]         from_node;
		logic [7:0]         command_code;
		logic [CNT_W-1:0]   packets_expected;
		logic [4:0]         chunk_bytes;
	} prps_item_t;

endpackage

// ----- design/prps_queue.sv -----
// ----------------------------------------------------------------------------
// prps_queue
// Small flop-based FIFO between the classifier and the context updater.
// ----------------------------------------------------------------------------
module prps_queue import prps_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  prps_item_t push_item,
	output logic       full,
	input  logic       pop,
	output prps_item_t head,
	output logic       empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	prps_item_t        mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue pop while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

endmodule

// ----- design/prps_front.sv -----
// ----------------------------------------------------------------------------
// prps_front
// Accepts packet headers, classifies them and works out the expected packet
// count of a new command as the size divided by the chunk payload, rounded up.
// ----------------------------------------------------------------------------
module prps_front import prps_pkg::*; #(
	parameter int SOURCES       = SOURCES_DEF,
	parameter int CHUNK_PAYLOAD = CHUNK_PAYLOAD_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  logic [3:0]   from_node,
	input  logic [3:0]   to_node,
	input  logic         is_command,
	input  logic [7:0]   command_code,
	input  logic [15:0]  message_size,
	input  logic [4:0]   chunk_bytes,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [7:0]   cfg_data,
	output logic         push,
	output prps_item_t   push_item,
	input  logic         q_full
);

	// ceil(size / d) = floor((size + d - 1) / d), done as a multiply by a
	// rounded-up reciprocal; exact for every 17-bit dividend
	localparam int XW  = SIZE_W + 1;
	localparam int MW  = XW + 1;
	localparam int PRW = XW + MW;
	localparam int RSH = XW + $clog2(CHUNK_PAYLOAD);
	localparam logic [MW-1:0] RECIP =
		MW'(((64'd1 << RSH) + 64'(CHUNK_PAYLOAD - 1)) / 64'(CHUNK_PAYLOAD));

	logic [7:0]          ack_code_q;
	logic [7:0]          noack_code_q;

	prps_item_t          in_item;
	logic                accept;
	logic [XW-1:0]       size_up;
	logic [PRW-1:0]      prod;
	logic [PRW-1:0]      quot;
	logic [CNT_W-1:0]    ceil_quot;

	assign cfg_ready = 1'b1;
	assign busy      = q_full;
	assign accept    = start && !busy;

	assign size_up   = {1'b0, message_size} + XW'(CHUNK_PAYLOAD - 1);
	assign prod      = PRW'(size_up) * PRW'(RECIP);
	assign quot      = prod >> RSH;
	assign ceil_quot = quot[CNT_W-1:0];

	// classify the incoming header
	always_comb begin
		in_item.from_node        = from_node;
		in_item.command_code     = command_code;
		in_item.packets_expected = ceil_quot;
		in_item.chunk_bytes      = chunk_bytes;
		priority if (from_node == SPECIAL_NODE && to_node == SPECIAL_NODE) begin
			in_item.kind = K_SPECIAL;
		end else if ({1'b0, from_node} >= 5'(SOURCES)) begin
			in_item.kind = K_OOB;
		end else if (is_command &&
			(command_code == ack_code_q || command_code == noack_code_q)) begin
			in_item.kind = K_STATUS;
		end else if (is_command) begin
			in_item.kind = K_CMD;
		end else begin
			in_item.kind = K_DATA;
		end
	end

	assign push      = accept;
	assign push_item = in_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_code_q   <= ACK_RESET;
			noack_code_q <= NOACK_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_ACK:   ack_code_q   <= cfg_data;
					CFG_NOACK: noack_code_q <= cfg_data;
					default:   ack_code_q   <= ack_code_q;
				endcase
			end
		end
	end

endmodule

// ----- design/prps_back.sv -----
// ----------------------------------------------------------------------------
// prps_back
// Holds the per-source reassembly contexts and produces one result per beat
// taken from the queue.
// ----------------------------------------------------------------------------
module prps_back import prps_pkg::*; #(
	parameter int SOURCES       = SOURCES_DEF,
	parameter int CHUNK_PAYLOAD = CHUNK_PAYLOAD_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  prps_item_t        head,
	output logic              pop,
	output logic              done,
	output logic [2:0]        event_res,
	output logic [4:0]        channel,
	output logic [7:0]        status_value,
	output logic [15:0]       write_offset,
	output logic [4:0]        byte_count,
	output logic [CNT_W-1:0]  packets_expected
);

	localparam int SW = $clog2(SOURCES);
	localparam int PW = CNT_W + 8;

	logic                cmd_seen_q [SOURCES];
	logic [CNT_W-1:0]    total_q    [SOURCES];
	logic [CNT_W-1:0]    rcvd_q     [SOURCES];

	logic                done_q;
	logic [2:0]          event_q;
	logic [4:0]          channel_q;
	logic [7:0]          status_q;
	logic [15:0]         offset_q;
	logic [4:0]          bytes_q;
	logic [CNT_W-1:0]    expected_q;

	logic [SW-1:0]       src;
	logic                seen;
	logic [CNT_W-1:0]    total;
	logic [CNT_W-1:0]    rcvd;
	logic [CNT_W-1:0]    rcvd_inc;
	logic [PW-1:0]       offset_full;

	logic [2:0]          ev;
	logic [7:0]          stat;
	logic [15:0]         off;
	logic [4:0]          cnt;
	logic [CNT_W-1:0]    expc;
	logic                ctx_clear;
	logic                ctx_start;
	logic                ctx_bump;

	assign pop = !q_empty;

	assign src         = head.from_node[SW-1:0];
	assign seen        = cmd_seen_q[src];
	assign total       = total_q[src];
	assign rcvd        = rcvd_q[src];
	assign rcvd_inc    = rcvd + CNT_W'(1);
	assign offset_full = PW'(rcvd) * PW'(CHUNK_PAYLOAD);

	always_comb begin
		ev        = EV_ORPHAN;
		stat      = '0;
		off       = '0;
		cnt       = '0;
		expc      = '0;
		ctx_clear = 1'b0;
		ctx_start = 1'b0;
		ctx_bump  = 1'b0;
		unique case (head.kind)
			K_SPECIAL, K_STATUS: begin
				ev   = EV_STATUS;
				stat = head.command_code;
			end
			K_OOB: begin
				ev = EV_ORPHAN;
			end
			K_CMD: begin
				if (seen) begin
					ev        = EV_REPEAT;
					ctx_clear = 1'b1;
				end else begin
					ev        = EV_START;
					expc      = head.packets_expected;
					ctx_start = 1'b1;
				end
			end
			K_DATA: begin
				if (!seen) begin
					ev        = EV_ORPHAN;
					ctx_clear = 1'b1;
				end else begin
					off  = offset_full[15:0];
					cnt  = head.chunk_bytes;
					expc = total;
					if (rcvd_inc == total) begin
						ev        = EV_DONE;
						ctx_clear = 1'b1;
					end else begin
						ev       = EV_PLACED;
						ctx_bump = 1'b1;
					end
				end
			end
			default: begin
				ev = EV_ORPHAN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SOURCES; i++) begin
				cmd_seen_q[i] <= 1'b0;
				total_q[i]    <= '0;
				rcvd_q[i]     <= '0;
			end
		end else if (pop) begin
			if (ctx_clear) begin
				cmd_seen_q[src] <= 1'b0;
				total_q[src]    <= '0;
				rcvd_q[src]     <= '0;
			end else if (ctx_start) begin
				cmd_seen_q[src] <= 1'b1;
				total_q[src]    <= head.packets_expected;
				rcvd_q[src]     <= '0;
			end else if (ctx_bump) begin
				rcvd_q[src] <= rcvd_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			event_q    <= ev;
			channel_q  <= (head.kind == K_SPECIAL) ? SPECIAL_CHANNEL : {1'b0, head.from_node};
			status_q   <= stat;
			offset_q   <= off;
			bytes_q    <= cnt;
			expected_q <= expc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= pop;
		end
	end

	assign done             = done_q;
	assign event_res        = event_q;
	assign channel          = channel_q;
	assign status_value     = status_q;
	assign write_offset     = offset_q;
	assign byte_count       = bytes_q;
	assign packets_expected = expected_q;

	a_pop_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> done)
		else $error("queue beat produced no result");

	a_special_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && channel == SPECIAL_CHANNEL) |-> event_res == EV_STATUS)
		else $error("special channel result with wrong event");

	a_no_stray_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(done && event_res != EV_PLACED && event_res != EV_DONE)
			|-> (write_offset == '0 && byte_count == '0))
		else $error("payload fields set on a non-data result");

endmodule

// ----- design/packet_reassembly_per_source_top.sv -----
// ----------------------------------------------------------------------------
// packet_reassembly_per_source_top
// Per-source packet reassembly tracker: one header in, one result out.
// ----------------------------------------------------------------------------
// A header is taken when start is high and busy is low. Every header is
// classified and, for a command, has its expected packet count worked out
// in the cycle it is taken, then passes through a two-entry queue to the
// context table, which drains one beat per cycle. The queue therefore never
// fills, busy stays low and headers can be issued every cycle. Each header
// yields exactly one result: it is written into the queue when taken, then
// popped into the result registers, and done is high for a single cycle
// with that result. The receiver cannot stall results. Configuration writes
// are always ready and take effect from the next header.
module packet_reassembly_per_source_top import prps_pkg::*; #(
	parameter int SOURCES       = SOURCES_DEF,
	parameter int CHUNK_PAYLOAD = CHUNK_PAYLOAD_DEF,
	parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [3:0]        from_node,
	input  logic [3:0]        to_node,
	input  logic              is_command,
	input  logic [7:0]        command_code,
	input  logic [15:0]       message_size,
	input  logic [4:0]        chunk_bytes,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data,
	output logic              done,
	output logic [2:0]        event_res,
	output logic [4:0]        channel,
	output logic [7:0]        status_value,
	output logic [15:0]       write_offset,
	output logic [4:0]        byte_count,
	output logic [CNT_W-1:0]  packets_expected
);

	logic        push;
	prps_item_t  push_item;
	logic        q_full;
	logic        q_empty;
	logic        pop;
	prps_item_t  head;

	prps_front #(
		.SOURCES       (SOURCES),
		.CHUNK_PAYLOAD (CHUNK_PAYLOAD)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.from_node    (from_node),
		.to_node      (to_node),
		.is_command   (is_command),
		.command_code (command_code),
		.message_size (message_size),
		.chunk_bytes  (chunk_bytes),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.push_item    (push_item),
		.q_full       (q_full)
	);

	prps_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty)
	);

	prps_back #(
		.SOURCES       (SOURCES),
		.CHUNK_PAYLOAD (CHUNK_PAYLOAD)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_empty          (q_empty),
		.head             (head),
		.pop              (pop),
		.done             (done),
		.event_res        (event_res),
		.channel          (channel),
		.status_value     (status_value),
		.write_offset     (write_offset),
		.byte_count       (byte_count),
		.packets_expected (packets_expected)
	);

endmodule
